@@ rtl/jst_pkg.sv @@
// jst_pkg: shared widths, operation, state and status codes for the job slot table
// result word type used by the controller and the output channel
// no dependencies
package jst_pkg;

    localparam int OP_W    = 3;
    localparam int ID_W    = 11;
    localparam int CST_W   = 3;
    localparam int AMT_W   = 31;
    localparam int STAT_W  = 2;
    localparam int STATE_W = 3;

    localparam int MAX_JOBS_DEF = 1024;

    localparam logic [AMT_W-1:0] TICK_STEP_RST = AMT_W'(65536);
    localparam logic [AMT_W-1:0] AMT_MAX       = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

    // create state codes as given on the input
    localparam logic [CST_W-1:0] CST_UNSET  = 3'd0;
    localparam logic [CST_W-1:0] CST_FAILED = 3'd5;

    // stored job state codes
    localparam logic [STATE_W-1:0] ST_PENDING   = 3'd0;
    localparam logic [STATE_W-1:0] ST_INPROG    = 3'd1;
    localparam logic [STATE_W-1:0] ST_COMPLETE  = 3'd2;
    localparam logic [STATE_W-1:0] ST_CANCELLED = 3'd3;
    localparam logic [STATE_W-1:0] ST_FAILED    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    new_id;
        logic [STATE_W-1:0] job_state;
        logic [AMT_W-1:0]   job_work;
        logic [AMT_W-1:0]   job_progress;
    } t_result;

endpackage

@@ rtl/jst_if.sv @@
// jst_if: valid/ready channels of the job slot table, operation in and result out
// depends on jst_pkg for field widths
interface jst_in_if;
    logic                       valid;
    logic                       ready;
    logic [jst_pkg::OP_W-1:0]   op;
    logic [jst_pkg::ID_W-1:0]   job_id;
    logic [jst_pkg::CST_W-1:0]  create_state;
    logic [jst_pkg::AMT_W-1:0]  work_amount;

    modport source (output valid, output op, output job_id, output create_state,
                    output work_amount, input ready);
    modport sink   (input valid, input op, input job_id, input create_state,
                    input work_amount, output ready);
endinterface

interface jst_out_if;
    logic                         valid;
    logic                         ready;
    logic [jst_pkg::STAT_W-1:0]   status;
    logic [jst_pkg::ID_W-1:0]     new_id;
    logic [jst_pkg::STATE_W-1:0]  job_state;
    logic [jst_pkg::AMT_W-1:0]    job_work;
    logic [jst_pkg::AMT_W-1:0]    job_progress;

    modport source (output valid, output status, output new_id, output job_state,
                    output job_work, output job_progress, input ready);
    modport sink   (input valid, input status, input new_id, input job_state,
                    input job_work, input job_progress, output ready);
endinterface

@@ rtl/jst_store.sv @@
// jst_store: slot memories, job state and {work, progress}, one write and one
// registered read port each; depends on jst_pkg for widths
module jst_store #(
    parameter int MAX_JOBS = jst_pkg::MAX_JOBS_DEF,
    parameter int IW       = $clog2(MAX_JOBS)
) (
    input  logic                            i_clk,
    input  logic                            i_rd_en,
    input  logic [IW-1:0]                   i_rd_addr,
    output logic [jst_pkg::STATE_W-1:0]     o_st_rdata,
    output logic [2*jst_pkg::AMT_W-1:0]     o_wp_rdata,
    input  logic                            i_st_we,
    input  logic [IW-1:0]                   i_st_waddr,
    input  logic [jst_pkg::STATE_W-1:0]     i_st_wdata,
    input  logic                            i_wp_we,
    input  logic [IW-1:0]                   i_wp_waddr,
    input  logic [2*jst_pkg::AMT_W-1:0]     i_wp_wdata
);
    import jst_pkg::*;

    logic [STATE_W-1:0]  m_state [MAX_JOBS];
    logic [2*AMT_W-1:0]  m_wp    [MAX_JOBS];

    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            m_state[i_st_waddr] <= i_st_wdata;
        end
        if (i_rd_en) begin
            o_st_rdata <= m_state[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wp_we) begin
            m_wp[i_wp_waddr] <= i_wp_wdata;
        end
        if (i_rd_en) begin
            o_wp_rdata <= m_wp[i_rd_addr];
        end
    end

endmodule

@@ rtl/jst_ctrl.sv @@
// jst_ctrl: operation sequencer, high-water count, tick walk and result registers
// depends on jst_pkg and jst_if; drives the ports of jst_store
module jst_ctrl #(
    parameter int MAX_JOBS = jst_pkg::MAX_JOBS_DEF,
    parameter int IW       = $clog2(MAX_JOBS)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [jst_pkg::AMT_W-1:0]       i_cfg_wdata,
    jst_in_if.sink                          i_in,
    jst_out_if.source                       o_out,
    output logic                            o_rd_en,
    output logic [IW-1:0]                   o_rd_addr,
    input  logic [jst_pkg::STATE_W-1:0]     i_st_rdata,
    input  logic [2*jst_pkg::AMT_W-1:0]     i_wp_rdata,
    output logic                            o_st_we,
    output logic [IW-1:0]                   o_st_waddr,
    output logic [jst_pkg::STATE_W-1:0]     o_st_wdata,
    output logic                            o_wp_we,
    output logic [IW-1:0]                   o_wp_waddr,
    output logic [2*jst_pkg::AMT_W-1:0]     o_wp_wdata
);
    import jst_pkg::*;

    localparam int HWW = $clog2(MAX_JOBS + 1);
    localparam int CW  = (HWW > ID_W) ? HWW : ID_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_QRD  = 4'b0010,
        S_TICK = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [HWW-1:0]     r_hw, n_hw;
    logic [HWW-1:0]     r_idx, n_idx;
    logic [IW-1:0]      r_wb_addr, n_wb_addr;
    logic [AMT_W-1:0]   r_tick_step;
    t_result            r_res, n_res;
    t_result            r_out;
    logic               r_out_vld;

    logic               acc;
    logic               out_free;
    logic [CW-1:0]      id_ext;
    logic [CW-1:0]      id_m1;
    logic [CW-1:0]      hw_p1;
    logic               id_ok;
    logic               full;
    logic [STATE_W-1:0] cst_mapped;
    logic [AMT_W-1:0]   rd_work;
    logic [AMT_W-1:0]   rd_prog;
    logic [AMT_W:0]     sum;
    logic [AMT_W-1:0]   prog_new;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;

    assign id_ext = CW'(i_in.job_id);
    assign id_m1  = id_ext - CW'(1);
    assign hw_p1  = CW'(r_hw) + CW'(1);
    assign id_ok  = (i_in.job_id != '0) && (id_ext <= CW'(r_hw));
    assign full   = (r_hw == HWW'(MAX_JOBS));

    always_comb begin
        if (i_in.create_state == CST_UNSET) begin
            cst_mapped = ST_PENDING;
        end else if (i_in.create_state <= CST_FAILED) begin
            cst_mapped = i_in.create_state - STATE_W'(1);
        end else begin
            cst_mapped = ST_FAILED;
        end
    end

    // saturating progress step
    assign rd_work  = i_wp_rdata[2*AMT_W-1:AMT_W];
    assign rd_prog  = i_wp_rdata[AMT_W-1:0];
    assign sum      = {1'b0, rd_prog} + {1'b0, r_tick_step};
    assign prog_new = sum[AMT_W] ? AMT_MAX : sum[AMT_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_hw       = r_hw;
        n_idx      = r_idx;
        n_wb_addr  = r_wb_addr;
        n_res      = r_res;
        o_rd_en    = 1'b0;
        o_rd_addr  = id_m1[IW-1:0];
        o_st_we    = 1'b0;
        o_st_waddr = id_m1[IW-1:0];
        o_st_wdata = ST_COMPLETE;
        o_wp_we    = 1'b0;
        o_wp_waddr = r_hw[IW-1:0];
        o_wp_wdata = {i_in.work_amount, AMT_W'(0)};

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_res   = '0;
                    n_state = S_RESP;
                    case (i_in.op)
                        OP_CREATE: begin
                            if (full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                o_st_we      = 1'b1;
                                o_st_waddr   = r_hw[IW-1:0];
                                o_st_wdata   = cst_mapped;
                                o_wp_we      = 1'b1;
                                n_hw         = r_hw + HWW'(1);
                                n_res.new_id = hw_p1[ID_W-1:0];
                            end
                        end
                        OP_QUERY: begin
                            if (id_ok) begin
                                o_rd_en = 1'b1;
                                n_state = S_QRD;
                            end else begin
                                n_res.status = STAT_BAD_ID;
                            end
                        end
                        OP_CANCEL, OP_COMPLETE: begin
                            if (id_ok) begin
                                o_st_we    = 1'b1;
                                o_st_wdata = (i_in.op == OP_CANCEL) ? ST_CANCELLED
                                                                    : ST_COMPLETE;
                            end else begin
                                n_res.status = STAT_BAD_ID;
                            end
                        end
                        OP_TICK: begin
                            if (r_hw != '0) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_wb_addr = '0;
                                n_idx     = HWW'(1);
                                n_state   = S_TICK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QRD: begin
                n_res.job_state    = i_st_rdata;
                n_res.job_work     = rd_work;
                n_res.job_progress = rd_prog;
                n_state            = S_RESP;
            end
            S_TICK: begin
                // write back the slot read last cycle, read the next one
                o_st_waddr = r_wb_addr;
                o_wp_waddr = r_wb_addr;
                o_wp_wdata = {rd_work, prog_new};
                if (i_st_rdata == ST_INPROG) begin
                    o_wp_we = 1'b1;
                    o_st_we = (prog_new >= rd_work);
                end
                if (r_idx < r_hw) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx[IW-1:0];
                    n_wb_addr = r_idx[IW-1:0];
                    n_idx     = r_idx + HWW'(1);
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw        <= '0;
            r_out_vld   <= 1'b0;
            r_tick_step <= TICK_STEP_RST;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            if (i_cfg_we) begin
                r_tick_step <= i_cfg_wdata;
            end
            if (r_state == S_RESP && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_wb_addr <= n_wb_addr;
        r_res     <= n_res;
        if (r_state == S_RESP && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.status       = r_out.status;
    assign o_out.new_id       = r_out.new_id;
    assign o_out.job_state    = r_out.job_state;
    assign o_out.job_work     = r_out.job_work;
    assign o_out.job_progress = r_out.job_progress;

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= HWW'(MAX_JOBS))
        else $error("high-water count beyond table size");

    a_hw_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_hw >= $past(r_hw))
        else $error("high-water count went down");

    a_tick_wb_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && o_wp_we) |-> (HWW'(r_wb_addr) < r_hw))
        else $error("tick write-back beyond high-water mark");

    a_resp_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP || r_state == S_QRD) |-> (!o_st_we && !o_wp_we))
        else $error("memory write outside create, cancel, complete or tick");

endmodule

@@ rtl/job_slot_table_with_progress_top.sv @@
// job_slot_table_with_progress_top: job slot table with tick-driven progress
// depends on jst_pkg, jst_if, jst_store and jst_ctrl
//
//  channel   dir  handshake              word
//  i_in      in   valid/ready            op, job_id, create_state, work_amount
//  o_out     out  valid/ready            status, new_id, job_state, job_work,
//                                        job_progress
//  cfg       in   i_cfg_we, no stall     tick_step
//
// one operation at a time; a good query passes through a memory read state before
// its reply, and a tick walks every slot below the high-water mark: the walk reads
// one slot per cycle and writes it back the next through the single read port,
// overlapped with the following read
// reset clears the high-water count, so no clearing pass is needed; slots are never
// freed, so every slot below the mark is in use
// a finished word waits in the output register while the next operation is taken;
// if the output register is still full the sequencer holds its result until it drains
module job_slot_table_with_progress_top #(
    parameter int MAX_JOBS = jst_pkg::MAX_JOBS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [jst_pkg::AMT_W-1:0]   i_cfg_wdata,
    jst_in_if.sink                      i_in,
    jst_out_if.source                   o_out
);
    import jst_pkg::*;

    localparam int IW = $clog2(MAX_JOBS);

    // memory read port
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [STATE_W-1:0]   st_rdata;
    logic [2*AMT_W-1:0]   wp_rdata;

    // job state write port
    logic                 st_we;
    logic [IW-1:0]        st_waddr;
    logic [STATE_W-1:0]   st_wdata;

    // work and progress write port
    logic                 wp_we;
    logic [IW-1:0]        wp_waddr;
    logic [2*AMT_W-1:0]   wp_wdata;

    // sequencer: decodes ops, owns the high-water count and the result registers
    jst_ctrl #(
        .MAX_JOBS (MAX_JOBS),
        .IW       (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_st_rdata  (st_rdata),
        .i_wp_rdata  (wp_rdata),
        .o_st_we     (st_we),
        .o_st_waddr  (st_waddr),
        .o_st_wdata  (st_wdata),
        .o_wp_we     (wp_we),
        .o_wp_waddr  (wp_waddr),
        .o_wp_wdata  (wp_wdata)
    );

    // slot storage, contents undefined until a create writes the slot
    jst_store #(
        .MAX_JOBS (MAX_JOBS),
        .IW       (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_st_rdata (st_rdata),
        .o_wp_rdata (wp_rdata),
        .i_st_we    (st_we),
        .i_st_waddr (st_waddr),
        .i_st_wdata (st_wdata),
        .i_wp_we    (wp_we),
        .i_wp_waddr (wp_waddr),
        .i_wp_wdata (wp_wdata)
    );

endmodule

@@ dv/job_slot_table_with_progress_top_tb.sv @@
`timescale 1ns / 1ps
// job_slot_table_with_progress_top_tb: self-checking bench for the job slot table top
// depends on jst_pkg, jst_if and job_slot_table_with_progress_top; predicts every reply word
module job_slot_table_with_progress_top_tb;
    import jst_pkg::*;

    localparam int SLOTS      = MAX_JOBS_DEF;
    // longest quiet stretch: a full-table tick plus stalls, taken many times over
    localparam int IDLE_LIMIT = 20000;

    // create states and op codes the package leaves unnamed
    localparam logic [CST_W-1:0] CST_PENDING   = 3'd1;
    localparam logic [CST_W-1:0] CST_INPROG    = 3'd2;
    localparam logic [CST_W-1:0] CST_COMPLETE  = 3'd3;
    localparam logic [CST_W-1:0] CST_CANCELLED = 3'd4;
    localparam logic [CST_W-1:0] CST_BAD_A     = 3'd6;
    localparam logic [CST_W-1:0] CST_BAD_B     = 3'd7;
    localparam logic [OP_W-1:0]  OP_UNUSED_A   = 3'd5;
    localparam logic [OP_W-1:0]  OP_UNUSED_B   = 3'd6;
    localparam logic [OP_W-1:0]  OP_UNUSED_C   = 3'd7;

    // reply words that can be written down without working anything out
    localparam t_result OK_WORD   = t_result'{STAT_OK, ID_W'(0), ST_PENDING, AMT_W'(0), AMT_W'(0)};
    localparam t_result BAD_WORD  = t_result'{STAT_BAD_ID, ID_W'(0), ST_PENDING, AMT_W'(0),
                                              AMT_W'(0)};

    typedef enum int {RX_OPEN, RX_SPOTTY, RX_BURSTY} t_rx_mode;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [CST_W-1:0] cst;
        logic [AMT_W-1:0] work;
        bit               typed;
        t_result          want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [AMT_W-1:0]   i_cfg_wdata;

    jst_in_if  in_ch ();
    jst_out_if out_ch ();

    job_slot_table_with_progress_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // shadow copy of the job table
    bit                 slot_taken [SLOTS];
    logic [STATE_W-1:0] slot_st    [SLOTS];
    logic [AMT_W-1:0]   slot_amt   [SLOTS];
    logic [AMT_W-1:0]   slot_prog  [SLOTS];
    int                 mark;
    logic [AMT_W-1:0]   step_cfg;

    t_result   job_replies [$];
    t_stim_row stim_rows [$];
    t_result   want_word;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;

    always #5 i_clk = ~i_clk;

    // applies one operation to the shadow table and returns the reply word it gives
    function automatic t_result apply_job_op(input logic [OP_W-1:0] op,
                                             input logic [ID_W-1:0] id,
                                             input logic [CST_W-1:0] cst,
                                             input logic [AMT_W-1:0] work);
        t_result        r;
        int             free_slot;
        bit             id_ok;
        logic [AMT_W:0] sum;
        r = '0;
        id_ok = 1'b0;
        if (id != 0 && int'(id) <= mark) id_ok = slot_taken[id - 1];
        case (op)
            OP_CREATE: begin
                free_slot = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_taken[i]) begin
                        free_slot = i;
                        break;
                    end
                end
                if (free_slot < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    slot_taken[free_slot] = 1'b1;
                    if (free_slot + 1 > mark) mark = free_slot + 1;
                    // unset maps to pending, codes past failed are stored as failed
                    if (cst == CST_UNSET) slot_st[free_slot] = ST_PENDING;
                    else if (cst <= CST_FAILED) slot_st[free_slot] = STATE_W'(cst - 3'd1);
                    else slot_st[free_slot] = ST_FAILED;
                    slot_amt[free_slot]  = work;
                    slot_prog[free_slot] = '0;
                    r.new_id = ID_W'(free_slot + 1);
                end
            end
            OP_QUERY, OP_CANCEL, OP_COMPLETE: begin
                if (!id_ok) begin
                    r.status = STAT_BAD_ID;
                end else if (op == OP_QUERY) begin
                    r.job_state    = slot_st[id - 1];
                    r.job_work     = slot_amt[id - 1];
                    r.job_progress = slot_prog[id - 1];
                end else if (op == OP_CANCEL) begin
                    slot_st[id - 1] = ST_CANCELLED;
                end else begin
                    slot_st[id - 1] = ST_COMPLETE;
                end
            end
            OP_TICK: begin
                for (int i = 0; i < mark; i++) begin
                    if (slot_taken[i] && slot_st[i] == ST_INPROG) begin
                        sum = {1'b0, slot_prog[i]} + {1'b0, step_cfg};
                        slot_prog[i] = (sum > AMT_MAX) ? AMT_MAX : sum[AMT_W-1:0];
                        if (slot_prog[i] >= slot_amt[i]) slot_st[i] = ST_COMPLETE;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offers one word, waits for it to be taken, then idles between bursts
    task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [CST_W-1:0] cst, input logic [AMT_W-1:0] work,
                           input bit typed = 1'b0, input t_result want = '0);
        t_result guess;
        int      gap;
        @(negedge i_clk);
        in_ch.valid        = 1'b1;
        in_ch.op           = op;
        in_ch.job_id       = id;
        in_ch.create_state = cst;
        in_ch.work_amount  = work;
        do @(posedge i_clk); while (!in_ch.ready);
        guess = apply_job_op(op, id, cst, work);
        job_replies.push_back(typed ? want : guess);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // random operation; creates are biased toward in-progress jobs so ticks have work
    task automatic send_random(input bit create_only);
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [CST_W-1:0] cst;
        logic [AMT_W-1:0] work;
        logic [63:0]      scaled;
        int               roll;
        roll = $urandom_range(0, 99);
        if (create_only || roll < 28) op = OP_CREATE;
        else if (roll < 56) op = OP_QUERY;
        else if (roll < 64) op = OP_CANCEL;
        else if (roll < 72) op = OP_COMPLETE;
        else if (roll < 92) op = OP_TICK;
        else begin
            case ($urandom_range(0, 2))
                0:       op = OP_UNUSED_A;
                1:       op = OP_UNUSED_B;
                default: op = OP_UNUSED_C;
            endcase
        end
        // mostly live ids, then zero, the top id and ids past the mark
        roll = $urandom_range(0, 99);
        if (roll < 75 && mark > 0) id = ID_W'($urandom_range(1, mark));
        else if (roll < 84) id = '0;
        else if (roll < 90 || mark >= SLOTS) id = ID_W'(SLOTS);
        else id = ID_W'($urandom_range(mark + 1, SLOTS));
        cst = ($urandom_range(0, 9) < 4) ? CST_INPROG : CST_W'($urandom_range(0, 7));
        // work near a few multiples of the step lands completions on either side of a tick
        case ($urandom_range(0, 7))
            0: work = '0;
            1: work = AMT_MAX;
            2, 3, 4: begin
                scaled = 64'(step_cfg) * $urandom_range(0, 6) + $urandom_range(0, 3);
                work = (scaled > 64'(AMT_MAX)) ? AMT_MAX : scaled[AMT_W-1:0];
            end
            default: work = AMT_W'($urandom);
        endcase
        send_op(op, id, cst, work);
    endtask

    // drain every reply, let the block go quiet, then load a new tick step
    task automatic retune_step(input logic [AMT_W-1:0] value);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (job_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        step_cfg    = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // receiver: open, spotty or long stalls, switching between them at random
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        bit       rx_low;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        rx_low    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   out_ch.ready = 1'b1;
                RX_SPOTTY: out_ch.ready = ($urandom_range(0, 3) != 0);
                default: begin
                    if (hold_left == 0) begin
                        rx_low    = !rx_low;
                        hold_left = rx_low ? $urandom_range(1, 12) : $urandom_range(1, 5);
                    end
                    hold_left--;
                    out_ch.ready = !rx_low;
                end
            endcase
        end
    end

    // reply checker: every taken word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (job_replies.size() == 0) begin
                $error("reply word with nothing predicted: status %0d new_id %0d",
                       out_ch.status, out_ch.new_id);
                mismatches++;
            end else begin
                want_word = job_replies.pop_front();
                if (out_ch.status !== want_word.status) begin
                    $error("status: expected %0d, got %0d", want_word.status, out_ch.status);
                    mismatches++;
                end
                if (out_ch.new_id !== want_word.new_id) begin
                    $error("new_id: expected %0d, got %0d", want_word.new_id, out_ch.new_id);
                    mismatches++;
                end
                if (out_ch.job_state !== want_word.job_state) begin
                    $error("job_state: expected %0d, got %0d", want_word.job_state,
                           out_ch.job_state);
                    mismatches++;
                end
                if (out_ch.job_work !== want_word.job_work) begin
                    $error("job_work: expected %0h, got %0h", want_word.job_work,
                           out_ch.job_work);
                    mismatches++;
                end
                if (out_ch.job_progress !== want_word.job_progress) begin
                    $error("job_progress: expected %0h, got %0h", want_word.job_progress,
                           out_ch.job_progress);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_CREATE;
        in_ch.job_id       = '0;
        in_ch.create_state = CST_UNSET;
        in_ch.work_amount  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_taken[i] = 1'b0;
            slot_st[i]    = ST_PENDING;
            slot_amt[i]   = '0;
            slot_prog[i]  = '0;
        end
        mark     = 0;
        step_cfg = TICK_STEP_RST;

        // directed rows, tick step still at its reset value
        // empty table: lookups fail, a tick does nothing
        stim_rows.push_back('{OP_QUERY, ID_W'(1), CST_UNSET, '0, 1'b1, BAD_WORD});
        stim_rows.push_back('{OP_TICK, '0, CST_UNSET, '0, 1'b1, OK_WORD});
        // a create for every state code, in progress twice, ids come out in order
        stim_rows.push_back('{OP_CREATE, '0, CST_UNSET, '0, 1'b1,
                              t_result'{STAT_OK, ID_W'(1), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_INPROG, AMT_MAX, 1'b1,
                              t_result'{STAT_OK, ID_W'(2), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_INPROG, AMT_W'(131072), 1'b1,
                              t_result'{STAT_OK, ID_W'(3), ST_PENDING, '0, '0}});
        // unknown create states are stored as failed
        stim_rows.push_back('{OP_CREATE, '0, CST_BAD_A, AMT_W'(5), 1'b1,
                              t_result'{STAT_OK, ID_W'(4), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_BAD_B, AMT_W'(32'h2AAA_AAAA), 1'b1,
                              t_result'{STAT_OK, ID_W'(5), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_PENDING, AMT_W'(32'h5555_5555), 1'b1,
                              t_result'{STAT_OK, ID_W'(6), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_COMPLETE, AMT_W'(1), 1'b1,
                              t_result'{STAT_OK, ID_W'(7), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_CANCELLED, '0, 1'b1,
                              t_result'{STAT_OK, ID_W'(8), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_CREATE, '0, CST_FAILED, TICK_STEP_RST, 1'b1,
                              t_result'{STAT_OK, ID_W'(9), ST_PENDING, '0, '0}});
        stim_rows.push_back('{OP_QUERY, ID_W'(4), CST_UNSET, '0, 1'b1,
                              t_result'{STAT_OK, '0, ST_FAILED, AMT_W'(5), '0}});
        // bad ids: zero, just past the mark, top of the range
        stim_rows.push_back('{OP_QUERY, '0, CST_UNSET, '0, 1'b1, BAD_WORD});
        stim_rows.push_back('{OP_QUERY, ID_W'(10), CST_UNSET, '0, 1'b1, BAD_WORD});
        stim_rows.push_back('{OP_QUERY, ID_W'(SLOTS), CST_BAD_B, AMT_MAX, 1'b1, BAD_WORD});
        // two ticks: job 3 reaches its work, pending job 1 stays put
        stim_rows.push_back('{OP_TICK, '0, CST_UNSET, '0, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_QUERY, ID_W'(3), CST_UNSET, '0, 1'b0, '0});
        stim_rows.push_back('{OP_TICK, '0, CST_UNSET, '0, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_QUERY, ID_W'(3), CST_UNSET, '0, 1'b0, '0});
        stim_rows.push_back('{OP_QUERY, ID_W'(1), CST_UNSET, '0, 1'b0, '0});
        stim_rows.push_back('{OP_CANCEL, ID_W'(2), CST_UNSET, '0, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_COMPLETE, ID_W'(1), CST_UNSET, '0, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_CANCEL, '0, CST_UNSET, '0, 1'b1, BAD_WORD});
        stim_rows.push_back('{OP_COMPLETE, ID_W'(SLOTS), CST_UNSET, '0, 1'b1, BAD_WORD});
        // unused op codes answer ok with nothing else
        stim_rows.push_back('{OP_UNUSED_A, ID_W'(3), CST_INPROG, AMT_MAX, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_UNUSED_B, ID_W'(1), CST_UNSET, '0, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_UNUSED_C, '0, CST_BAD_B, AMT_MAX, 1'b1, OK_WORD});
        stim_rows.push_back('{OP_QUERY, ID_W'(2), CST_UNSET, '0, 1'b0, '0});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[k])
            send_op(stim_rows[k].op, stim_rows[k].id, stim_rows[k].cst, stim_rows[k].work,
                    stim_rows[k].typed, stim_rows[k].want);

        // smallest step: slow jobs pick up a little progress
        retune_step(AMT_W'(1));
        repeat (120) send_random(1'b0);
        // zero step: ticks complete only jobs whose work is already covered
        retune_step('0);
        repeat (100) send_random(1'b0);
        // largest step: jobs carrying progress saturate
        retune_step(AMT_MAX);
        repeat (110) send_random(1'b0);
        // random step, with one full drain in the middle of the phase
        retune_step(AMT_W'($urandom));
        repeat (60) send_random(1'b0);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (job_replies.size() != 0) @(posedge i_clk);
        repeat (60) send_random(1'b0);
        // back to the reset step for a last mixed run
        retune_step(TICK_STEP_RST);
        repeat (90) send_random(1'b0);

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (job_replies.size() != 0) @(posedge i_clk);
        // room for one full-table walk to show any stray word
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/jst_pkg.sv
rtl/jst_if.sv
rtl/jst_store.sv
rtl/jst_ctrl.sv
rtl/job_slot_table_with_progress_top.sv
dv/job_slot_table_with_progress_top_tb.sv
